// ===== rtl/sahint_pkg.sv =====
package sahint_pkg;

    localparam int unsigned MAX_SLOTS_DEF = 64;
    localparam int unsigned CFG_W         = 7;
    localparam int unsigned IDX_W         = 6;
    localparam int unsigned GRANT_W       = 6;
    localparam int unsigned IN_DATA_W     = 8;
    localparam int unsigned OUT_DATA_W    = 8;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic {
        MODE_ALLOC = 1'b0,
        MODE_FREE  = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // state update issued for one request
    typedef struct packed {
        logic set_used;
        logic clr_used;
        logic load_hint;
    } t_slot_op;

endpackage

// ===== rtl/sahint_pick.sv =====
module sahint_pick
    import sahint_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int unsigned SLOT_W    = $clog2(MAX_SLOTS),
    parameter int unsigned CNT_W     = CFG_W
) (
    input  logic [MAX_SLOTS-1:0] i_used,
    input  logic [SLOT_W-1:0]    i_hint,
    input  logic [CNT_W-1:0]     i_count,
    output logic                 o_found,
    output logic [SLOT_W-1:0]    o_pick
);

    logic [MAX_SLOTS-1:0] avail;
    logic [MAX_SLOTS-1:0] lowest;
    logic [SLOT_W-1:0]    first;
    logic                 hint_ok;

    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            avail[i] = !i_used[i] && (CNT_W'(i) < i_count);
        end
    end

    // isolate the lowest free slot, then encode it
    assign lowest = avail & (~avail + MAX_SLOTS'(1));

    always_comb begin
        first = '0;
        for (int b = 0; b < SLOT_W; b++) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                if (i[b]) begin
                    first[b] = first[b] | lowest[i];
                end
            end
        end
    end

    assign hint_ok = (CNT_W'(i_hint) < i_count) && !i_used[i_hint];
    assign o_found = hint_ok || (|avail);
    assign o_pick  = hint_ok ? i_hint : first;

endmodule

// ===== rtl/sahint_state.sv =====
module sahint_state
    import sahint_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int unsigned SLOT_W    = $clog2(MAX_SLOTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_slot_op             i_op,
    input  logic [SLOT_W-1:0]    i_slot,
    input  logic [SLOT_W-1:0]    i_hint,
    output logic [MAX_SLOTS-1:0] o_used,
    output logic [SLOT_W-1:0]    o_hint
);

    logic [MAX_SLOTS-1:0] r_used;
    logic [SLOT_W-1:0]    r_hint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_hint <= '0;
        end else begin
            if (i_op.set_used) begin
                r_used[i_slot] <= 1'b1;
            end else if (i_op.clr_used) begin
                r_used[i_slot] <= 1'b0;
            end
            if (i_op.load_hint) begin
                r_hint <= i_hint;
            end
        end
    end

    assign o_used = r_used;
    assign o_hint = r_hint;

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_hint) < MAX_SLOTS))
        else $error("hint beyond slot storage");

    a_free_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.clr_used |=> !r_used[$past(i_slot)])
        else $error("freed slot still marked used");

endmodule

// ===== rtl/slot_allocator_with_hint_core.sv =====
// Slot allocator with a next-free hint.
// Requests arrive on the s_axis channel: tuser carries the kind (0 allocate,
// 1 free), tdata[5:0] the slot to free. Every request yields one result on
// m_axis: tuser carries the status (0 done, 1 pool full, 2 free index out of
// range), tdata[5:0] the granted slot (zero unless an allocate succeeded).
// The cfg channel writes the active slot count; it is always ready. The user
// must keep it written only while no request is in flight; nothing enforces it.
// A request is caught in an input register, decided combinationally against the
// used-bit vector and the hint, and written to the result register. One
// request per cycle is sustained while the receiver takes results; the
// first-free search is a single priority encoder over the used bits.
// Reset clears every used bit, zeroes the hint and sets the slot count to 64;
// no clearing pass is needed.
// When the receiver stalls the result holds, one more request is parked in
// the input register, and s_axis_tready drops until the result is taken.
module slot_allocator_with_hint_core
    import sahint_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [5:0] slot_index
    input  logic                  s_axis_tuser,   // [0] mode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] granted_slot
    output logic [1:0]            m_axis_tuser,   // [1:0] status
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int unsigned SLOT_W = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W  =
        ($clog2(MAX_SLOTS + 1) > CFG_W) ? $clog2(MAX_SLOTS + 1) : CFG_W;

    logic [CFG_W-1:0]     r_slots;
    logic                 r_req_valid;
    t_mode                r_mode;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_out_valid;
    t_status              r_status;
    logic [GRANT_W-1:0]   r_grant;

    logic                 advance;
    logic [CNT_W-1:0]     count;
    logic [MAX_SLOTS-1:0] used;
    logic [SLOT_W-1:0]    hint;
    logic                 found;
    logic [SLOT_W-1:0]    pick;
    logic [CNT_W-1:0]     pick_next;
    t_slot_op             op;
    logic [SLOT_W-1:0]    op_slot;
    logic [SLOT_W-1:0]    op_hint;
    t_status              n_status;
    logic [GRANT_W-1:0]   n_grant;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slots <= i_cfg_data;
        end
    end

    assign count = (CNT_W'(r_slots) < CNT_W'(MAX_SLOTS)) ? CNT_W'(r_slots)
                                                         : CNT_W'(MAX_SLOTS);

    // input register
    assign advance       = r_req_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_req_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_req_valid <= 1'b1;
        end else if (advance) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_mode <= t_mode'(s_axis_tuser);
            r_idx  <= s_axis_tdata[IDX_W-1:0];
        end
    end

    sahint_pick #(
        .MAX_SLOTS (MAX_SLOTS),
        .SLOT_W    (SLOT_W),
        .CNT_W     (CNT_W)
    ) u_pick (
        .i_used  (used),
        .i_hint  (hint),
        .i_count (count),
        .o_found (found),
        .o_pick  (pick)
    );

    assign pick_next = CNT_W'(pick) + CNT_W'(1);

    // request decision
    always_comb begin
        op       = '0;
        op_slot  = pick;
        op_hint  = '0;
        n_status = ST_DONE;
        n_grant  = '0;
        if (r_mode == MODE_ALLOC) begin
            if (found) begin
                op.set_used  = advance;
                op.load_hint = advance;
                op_hint      = (pick_next >= count) ? '0 : pick_next[SLOT_W-1:0];
                n_grant      = GRANT_W'(pick);
            end else begin
                n_status = ST_FULL;
            end
        end else begin
            if (CNT_W'(r_idx) < count) begin
                op.clr_used  = advance;
                op.load_hint = advance;
                op_slot      = SLOT_W'(r_idx);
                op_hint      = SLOT_W'(r_idx);
            end else begin
                n_status = ST_RANGE;
            end
        end
    end

    sahint_state #(
        .MAX_SLOTS (MAX_SLOTS),
        .SLOT_W    (SLOT_W)
    ) u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_slot  (op_slot),
        .i_hint  (op_hint),
        .o_used  (used),
        .o_hint  (hint)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status <= n_status;
            r_grant  <= n_grant;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {{(OUT_DATA_W - GRANT_W){1'b0}}, r_grant};

    a_grant_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_mode == MODE_ALLOC && found) |-> !used[pick])
        else $error("allocate granted a slot already in use");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_DONE) |-> (m_axis_tdata == '0))
        else $error("granted slot set on a failed request");

    a_req_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && !advance) |=> r_req_valid)
        else $error("pending request dropped without a result");

endmodule

// ===== tb/slot_grant_checker.sv =====
`timescale 1ns / 1ps

module slot_grant_checker
    import sahint_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [5:0] slot_index
    input  logic                  s_axis_tuser,   // [0] mode
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] granted_slot
    input  logic [1:0]            m_axis_tuser,   // [1:0] status
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output int unsigned           o_fail_count,
    output int unsigned           o_pending
);

    typedef struct packed {
        t_status            status;
        logic [GRANT_W-1:0] slot;
    } t_grant;

    t_grant                   expected_grants[$];
    logic [MAX_SLOTS_DEF-1:0] busy_map;
    logic [IDX_W-1:0]         next_hint;
    logic [CFG_W-1:0]         pool_size;
    int unsigned              mismatches = 0;

    // updates the shadow pool and returns what the block must answer
    function automatic t_grant grant_or_release(input t_mode kind, input logic [IDX_W-1:0] idx);
        t_grant      res;
        int unsigned n;
        int unsigned pick;
        int unsigned i;
        n          = (pool_size < MAX_SLOTS_DEF) ? pool_size : MAX_SLOTS_DEF;
        res.status = ST_DONE;
        res.slot   = '0;
        if (kind == MODE_ALLOC) begin
            pick = n;
            if (next_hint < n && !busy_map[next_hint]) begin
                pick = next_hint;
            end else begin
                for (i = 0; i < n; i++) begin
                    if (!busy_map[i]) begin
                        pick = i;
                        break;
                    end
                end
            end
            if (pick >= n) begin
                res.status = ST_FULL;
            end else begin
                busy_map[pick] = 1'b1;
                res.slot       = pick[GRANT_W-1:0];
                next_hint      = (pick + 1 >= n) ? '0 : IDX_W'(pick + 1);
            end
        end else if (idx < n) begin
            busy_map[idx] = 1'b0;
            next_hint     = idx;
        end else begin
            res.status = ST_RANGE;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_grant want;
        t_status got_status;
        logic [GRANT_W-1:0] got_slot;
        if (!i_rst_n) begin
            busy_map  = '0;
            next_hint = '0;
            pool_size = CFG_RESET;
            expected_grants.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                pool_size = i_cfg_data;
            if (m_axis_tvalid && m_axis_tready) begin
                got_status = t_status'(m_axis_tuser);
                got_slot   = m_axis_tdata[GRANT_W-1:0];
                if (expected_grants.size() == 0) begin
                    $error("unexpected result: status %0d granted_slot %0d",
                           got_status, got_slot);
                    mismatches++;
                end else begin
                    want = expected_grants.pop_front();
                    if (got_status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, got_status);
                        mismatches++;
                    end
                    if (got_slot !== want.slot) begin
                        $error("granted_slot: expected %0d actual %0d", want.slot, got_slot);
                        mismatches++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_grants.push_back(grant_or_release(t_mode'(s_axis_tuser),
                                                           s_axis_tdata[IDX_W-1:0]));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_grants.size();
    end

endmodule

// ===== tb/tb_slot_allocator_with_hint_core.sv =====
`timescale 1ns / 1ps

module tb_slot_allocator_with_hint_core;
    import sahint_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned LONG_HOLD   = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [5:0] slot_index
    logic                  s_axis_tuser;   // [0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [5:0] granted_slot
    logic [1:0]            m_axis_tuser;   // [1:0] status
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_W-1:0]      i_cfg_data;
    int unsigned           fail_count;
    int unsigned           pending;

    bit                    idle_on;
    bit                    long_hold_go;
    int unsigned           cur_slots;

    slot_allocator_with_hint_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    slot_grant_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic offer(input t_mode kind, input logic [IDX_W-1:0] idx);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_pool(input logic [CFG_W-1:0] size);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_slots = size;
    endtask

    task automatic random_request(input int unsigned alloc_pct);
        int unsigned active;
        active = (cur_slots < MAX_SLOTS_DEF) ? cur_slots : MAX_SLOTS_DEF;
        if ($urandom_range(0, 99) < alloc_pct)
            offer(MODE_ALLOC, IDX_W'($urandom));
        else if (active == 0 || $urandom_range(0, 3) == 0)
            offer(MODE_FREE, IDX_W'($urandom));
        else
            offer(MODE_FREE, IDX_W'($urandom_range(0, active - 1)));
    endtask

    initial begin : result_sink
        int unsigned hold;
        int unsigned r;
        hold          = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_go) begin
                long_hold_go = 1'b0;
                hold         = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (!idle_on) begin
                m_axis_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_W-1:0] sizes [10];
        int unsigned      p;
        int unsigned      k;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        idle_on       = 1'b1;
        long_hold_go  = 1'b0;
        cur_slots     = CFG_RESET;
        sizes         = '{7'd64, 7'd1, 7'd127, 7'd2, 7'd33, 7'd0, 7'd100, 7'd65,
                          7'd7, 7'd64};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill from the bottom, reuse a freed slot, hint wrap at the top
        offer(MODE_ALLOC, 6'd0);
        offer(MODE_ALLOC, 6'h3F);
        offer(MODE_ALLOC, 6'd0);
        offer(MODE_FREE, 6'd1);
        offer(MODE_ALLOC, 6'd0);
        offer(MODE_FREE, 6'd63);    // slot already free
        offer(MODE_ALLOC, 6'd0);
        offer(MODE_ALLOC, 6'd0);
        // small pool: full, out of range frees
        set_pool(7'd4);
        offer(MODE_ALLOC, 6'd0);
        offer(MODE_FREE, 6'd4);
        offer(MODE_FREE, 6'd63);
        offer(MODE_FREE, 6'd2);
        // shrink the pool below the hint
        set_pool(7'd2);
        offer(MODE_ALLOC, 6'd0);
        offer(MODE_FREE, 6'd0);
        offer(MODE_ALLOC, 6'd0);
        set_pool(7'd0);
        offer(MODE_ALLOC, 6'd0);
        offer(MODE_FREE, 6'd0);
        // count above the slot limit saturates
        set_pool(7'd127);
        offer(MODE_ALLOC, 6'd0);
        offer(MODE_FREE, 6'd63);
        offer(MODE_ALLOC, 6'd0);
        set_pool(7'd1);
        offer(MODE_ALLOC, 6'd0);
        offer(MODE_FREE, 6'd0);
        offer(MODE_ALLOC, 6'd0);

        for (p = 0; p < 10; p++) begin
            set_pool((p == 9) ? CFG_W'($urandom_range(0, 127)) : sizes[p]);
            idle_on = (p != 2);
            for (k = 0; k < 60; k++) begin
                // receiver holds off while requests keep coming
                if ((p == 0 || p == 6) && k == 10)
                    long_hold_go = 1'b1;
                random_request((k < 30) ? 85 : $urandom_range(20, 60));
            end
        end

        settle();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
